[rtl/dpp_pkg.sv]
// Shared types and constants for the depth pixel to point block.
// No dependencies.
package dpp_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_FOCAL_LENGTH = 3'd2,
        CFG_MIN_DEPTH    = 3'd3,
        CFG_MAX_DEPTH    = 3'd4
    } t_cfg_idx;

    localparam int DEPTH_W  = 16;
    localparam int SIZE_W   = 13;
    localparam int FOCAL_W  = 12;
    localparam int HALF_W   = 12;
    localparam int RESULT_W = 16;

    // Per-transaction side information carried down the pipeline
    typedef struct packed {
        logic kept;
        logic neg_x;
        logic neg_y;
    } t_meta;

endpackage

[rtl/dpp_front.sv]
// Front end: bound check, centre offsets, squares, norm square and numerators.
// Depends on dpp_pkg. Three register stages sharing one advance enable.
module dpp_front import dpp_pkg::*; #(
    parameter int CB = 12,
    parameter int AW = 12,
    parameter int SW = 26,
    parameter int TW = 58
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DEPTH_W-1:0] i_depth,
    input  logic [CB-1:0]     i_column,
    input  logic [CB-1:0]     i_row,
    input  logic [SIZE_W-1:0] i_image_width,
    input  logic [SIZE_W-1:0] i_image_height,
    input  logic [FOCAL_W-1:0] i_focal_length,
    input  logic [DEPTH_W-1:0] i_min_depth,
    input  logic [DEPTH_W-1:0] i_max_depth,
    output logic              o_valid,
    output t_meta             o_meta,
    output logic [SW-1:0]     o_s,
    output logic [TW-1:0]     o_t_x,
    output logic [TW-1:0]     o_t_y,
    output logic [TW-1:0]     o_t_z
);
    localparam int NW = DEPTH_W + AW;

    logic [AW:0]   n_dx, n_dy;
    logic [AW-1:0] n_ax, n_ay;
    logic          n_kept;

    logic [2:0]          r_vld;
    t_meta               r_meta1, r_meta2, r_meta3;
    logic [DEPTH_W-1:0]  r_d1;
    logic [AW-1:0]       r_ax1, r_ay1, r_f1;
    logic [2*AW-1:0]     r_sqx, r_sqy, r_sqf;
    logic [NW-1:0]       r_nx, r_ny, r_nz;
    logic [SW-1:0]       r_s;
    logic [TW-1:0]       r_tx, r_ty, r_tz;

    // Offsets from the halved image size and their magnitudes
    always_comb begin
        n_dx = (AW+1)'(i_column) - (AW+1)'(i_image_width[SIZE_W-1:1]);
        n_dy = (AW+1)'(i_row) - (AW+1)'(i_image_height[SIZE_W-1:1]);
        n_ax = n_dx[AW] ? AW'(-n_dx) : n_dx[AW-1:0];
        n_ay = n_dy[AW] ? AW'(-n_dy) : n_dy[AW-1:0];
        n_kept = (i_min_depth < i_depth) && (i_depth < i_max_depth);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // Data path stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta1 <= '{kept: n_kept, neg_x: n_dx[AW], neg_y: n_dy[AW]};
            r_d1    <= i_depth;
            r_ax1   <= n_ax;
            r_ay1   <= n_ay;
            r_f1    <= AW'(i_focal_length);

            r_meta2 <= r_meta1;
            r_sqx   <= (2*AW)'(r_ax1) * (2*AW)'(r_ax1);
            r_sqy   <= (2*AW)'(r_ay1) * (2*AW)'(r_ay1);
            r_sqf   <= (2*AW)'(r_f1) * (2*AW)'(r_f1);
            r_nx    <= NW'(r_d1) * NW'(r_ax1);
            r_ny    <= NW'(r_d1) * NW'(r_ay1);
            r_nz    <= NW'(r_d1) * NW'(r_f1);

            r_meta3 <= r_meta2;
            r_s     <= SW'(r_sqx) + SW'(r_sqy) + SW'(r_sqf);
            r_tx    <= TW'({r_nx, 1'b0}) * TW'({r_nx, 1'b0});
            r_ty    <= TW'({r_ny, 1'b0}) * TW'({r_ny, 1'b0});
            r_tz    <= TW'({r_nz, 1'b0}) * TW'({r_nz, 1'b0});
        end
    end

    assign o_valid = r_vld[2];
    assign o_meta  = r_meta3;
    assign o_s     = r_s;
    assign o_t_x   = r_tx;
    assign o_t_y   = r_ty;
    assign o_t_z   = r_tz;

endmodule

[rtl/dpp_root_step.sv]
// One bit of the rounded quotient n/sqrt(s), decided by shift-and-add only.
// Depends on dpp_pkg. Tracks A=(2q-1)^2*s and B=(2q-1)*s for the prefix q.
module dpp_root_step import dpp_pkg::*; #(
    parameter int K  = 0,
    parameter int SW = 26,
    parameter int TW = 58,
    parameter int CW = 62
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [SW-1:0]        i_s,
    input  logic [TW-1:0]        i_t,
    input  logic signed [CW-1:0] i_a,
    input  logic signed [CW-1:0] i_b,
    input  logic [RESULT_W-1:0]  i_q,
    output logic [SW-1:0]        o_s,
    output logic [TW-1:0]        o_t,
    output logic signed [CW-1:0] o_a,
    output logic signed [CW-1:0] o_b,
    output logic [RESULT_W-1:0]  o_q
);
    logic signed [CW-1:0] n_cand;
    logic                 n_take;

    // Try setting bit K: (2q-1+2^(K+1))^2*s against 4n^2
    always_comb begin
        n_cand = i_a + (i_b <<< (K + 2)) + (CW'(i_s) << (2 * K + 2));
        n_take = (n_cand <= $signed(CW'(i_t)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_s <= i_s;
            o_t <= i_t;
            if (n_take) begin
                o_a    <= n_cand;
                o_b    <= i_b + (CW'(i_s) << (K + 1));
                o_q    <= i_q | (RESULT_W'(1) << K);
            end else begin
                o_a    <= i_a;
                o_b    <= i_b;
                o_q    <= i_q;
            end
        end
    end

endmodule

[rtl/depth_pixel_to_point.sv]
// Depth pixel to 3-D point unprojection.
// Input channel: i_in_valid/o_in_ready with depth (Q4.12), column and row.
// Output channel: o_out_valid/i_out_ready with kept flag, x and y (signed 17-bit, Q4.12 magnitude) and z (Q4.12).
// Config channel: i_cfg_valid/o_cfg_ready with a register index and data;
// always ready. Write only while the pipeline is empty.
// Throughput: one pixel per cycle while the output is not stalled.
// Pipeline: 20 register stages, namely three front stages (offsets,
// products, norm square and squared numerators), sixteen root stages
// deciding one result bit each for all three axes, and one output stage.
// Each result is round(depth*m/sqrt(dx^2+dy^2+f^2)), ties away from zero.
// Rejected pixels give zeros with kept low.
// Reset: pipeline empties and registers return to 640x480, focal 628,
// bounds 0.4 m and 5.0 m.
// Stall: when the output register is full and not taken, the whole
// pipeline holds; o_in_ready drops and no transaction is lost or repeated.
// Depends on dpp_pkg, dpp_front, dpp_root_step.
module depth_pixel_to_point import dpp_pkg::*; #(
    parameter int COORD_BITS      = 12,
    parameter int DEPTH_FRAC_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [DEPTH_W-1:0]    i_depth,
    input  logic [COORD_BITS-1:0] i_column,
    input  logic [COORD_BITS-1:0] i_row,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_point_kept,
    output logic signed [16:0]    o_point_x,
    output logic signed [16:0]    o_point_y,
    output logic [DEPTH_W-1:0]    o_point_z,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);
    localparam int AW = (COORD_BITS > HALF_W) ? COORD_BITS : HALF_W;
    localparam int SW = 2 * AW + 2;
    localparam int NW = DEPTH_W + AW;
    localparam int TW = 2 * NW + 2;
    localparam int CW = 2 * (RESULT_W + 1) + SW + 2;
    localparam int NB = RESULT_W;
    localparam int MIN_RST = (4 * (1 << DEPTH_FRAC_BITS) + 5) / 10;
    localparam int MAX_RAW = 5 * (1 << DEPTH_FRAC_BITS);
    localparam int MAX_RST = (MAX_RAW > 65535) ? 65535 : MAX_RAW;

    logic [SIZE_W-1:0]  r_image_width, r_image_height;
    logic [FOCAL_W-1:0] r_focal_length;
    logic [DEPTH_W-1:0] r_min_depth, r_max_depth;

    logic w_en;
    logic w_front_vld;
    t_meta w_front_meta;
    logic [SW-1:0] w_front_s;
    logic [TW-1:0] w_front_t [3];

    logic [SW-1:0]        w_s [3][NB+1];
    logic [TW-1:0]        w_t [3][NB+1];
    logic signed [CW-1:0] w_a [3][NB+1];
    logic signed [CW-1:0] w_b [3][NB+1];
    logic [RESULT_W-1:0]  w_q [3][NB+1];

    logic [NB-1:0] r_vld;
    t_meta         r_meta [NB];
    logic          r_out_vld;
    logic          n_zero;

    // Hold the pipeline while the output register is full and not taken
    assign w_en        = !r_out_vld || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= SIZE_W'(640);
            r_image_height <= SIZE_W'(480);
            r_focal_length <= FOCAL_W'(628);
            r_min_depth    <= DEPTH_W'(MIN_RST);
            r_max_depth    <= DEPTH_W'(MAX_RST);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[SIZE_W-1:0];
                CFG_FOCAL_LENGTH: r_focal_length <= i_cfg_data[FOCAL_W-1:0];
                CFG_MIN_DEPTH:    r_min_depth    <= i_cfg_data;
                CFG_MAX_DEPTH:    r_max_depth    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dpp_front #(.CB(COORD_BITS), .AW(AW), .SW(SW), .TW(TW)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_in_valid),
        .i_depth        (i_depth),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_focal_length (r_focal_length),
        .i_min_depth    (r_min_depth),
        .i_max_depth    (r_max_depth),
        .o_valid        (w_front_vld),
        .o_meta         (w_front_meta),
        .o_s            (w_front_s),
        .o_t_x          (w_front_t[0]),
        .o_t_y          (w_front_t[1]),
        .o_t_z          (w_front_t[2])
    );

    // Root stages: one result bit per stage, most significant first
    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_s[l][0] = w_front_s;
        assign w_t[l][0] = w_front_t[l];
        assign w_a[l][0] = $signed(CW'(w_front_s));
        assign w_b[l][0] = -$signed(CW'(w_front_s));
        assign w_q[l][0] = '0;
        for (genvar j = 0; j < NB; j++) begin : g_bit
            dpp_root_step #(.K(NB - 1 - j), .SW(SW), .TW(TW), .CW(CW)) u_step (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_s   (w_s[l][j]),
                .i_t   (w_t[l][j]),
                .i_a   (w_a[l][j]),
                .i_b   (w_b[l][j]),
                .i_q   (w_q[l][j]),
                .o_s   (w_s[l][j+1]),
                .o_t   (w_t[l][j+1]),
                .o_a   (w_a[l][j+1]),
                .o_b   (w_b[l][j+1]),
                .o_q   (w_q[l][j+1])
            );
        end
    end

    // Advance valid bits alongside the root stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[NB-2:0], w_front_vld};
            r_out_vld <= r_vld[NB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_meta[0] <= w_front_meta;
            for (int i = 1; i < NB; i++) begin
                r_meta[i] <= r_meta[i-1];
            end
        end
    end

    // Output register: zero rejected or zero-norm points, apply signs
    assign n_zero = !r_meta[NB-1].kept || (w_s[2][NB] == '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_point_kept <= r_meta[NB-1].kept;
            if (n_zero) begin
                o_point_x <= '0;
                o_point_y <= '0;
                o_point_z <= '0;
            end else begin
                o_point_x <= r_meta[NB-1].neg_x ? -$signed({1'b0, w_q[0][NB]})
                                                : $signed({1'b0, w_q[0][NB]});
                o_point_y <= r_meta[NB-1].neg_y ? -$signed({1'b0, w_q[1][NB]})
                                                : $signed({1'b0, w_q[1][NB]});
                o_point_z <= w_q[2][NB];
            end
        end
    end

    assign o_out_valid = r_out_vld;

endmodule
